/* rtl/md5_pkg.sv */
// md5_pkg: shared types, constants and round tables for the md5 engine
// no dependencies
`default_nettype none
package md5_pkg;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [1:0]  word_index;
      logic        last_word;
   } rsp_type;

   localparam logic CMD_ABSORB = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;

   localparam int unsigned BUF_DEPTH = 16;

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
         6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
         6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
         6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
         6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [5:0] i);
      logic [4:0] s;
      case ({i[5:4], i[1:0]})
         4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
         4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
         4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'ha: s = 5'd16; 4'hb: s = 5'd23;
         4'hc: s = 5'd6;  4'hd: s = 5'd10; 4'he: s = 5'd15; 4'hf: s = 5'd21;
         default: s = 5'd0;
      endcase
      return s;
   endfunction

   // message word index per round
   function automatic logic [3:0] msg_index(input logic [5:0] i);
      logic [3:0] g;
      case (i[5:4])
         2'd0: g = i[3:0];
         2'd1: g = 4'(5 * i[3:0] + 1);
         2'd2: g = 4'(3 * i[3:0] + 5);
         2'd3: g = 4'(7 * i[3:0]);
         default: g = 4'd0;
      endcase
      return g;
   endfunction

endpackage
`default_nettype wire

/* rtl/md5_ram.sv */
// md5_ram: generic simple dual-port ram (one write port, one read port), registered read
// no dependencies
`default_nettype none
module md5_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

/* rtl/md5_message_digest.sv */
// md5_message_digest: streaming md5 engine, top level
// depends on md5_pkg and md5_ram
//
// usage:
//   req channel: one request per message byte (command absorb) or a finish
//   request that pads the message and hashes the final block(s)
//   rsp channel: after a finish, four digest words, index 0 to 3, the last
//   one flagged with last_word; the bytes of each word enter the digest
//   least significant first
//   an absorb merges the byte into its block word via a read-modify-write
//   of the 16-word buffer ram; the 64th byte of a block starts a
//   compression, one round per cycle through a single round unit, paced
//   by the buffer ram read port, then folded into the chaining words
//   a finish writes the padding one word per cycle, compresses once or
//   twice, then offers the four words
//   the engine stalls while the receiver holds rsp_ready low and reinits
//   its chaining words and bit count when the last word is taken
//   reset: chaining words take the md5 initial values, bit count clears;
//   the buffer ram needs no clearing since every byte is written first
`default_nettype none
module md5_message_digest (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire md5_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      md5_pkg::rsp_type rsp_data
);
   localparam int unsigned BufDepth = md5_pkg::BUF_DEPTH;
   localparam int unsigned AW = $clog2(BufDepth);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MERGE = 3'd1;
   localparam logic [2:0] ST_PAD   = 3'd2;
   localparam logic [2:0] ST_ROUND = 3'd3;
   localparam logic [2:0] ST_FOLD  = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [31:0] h_ff [4];
   logic [31:0] h_in [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, a_in, b_in, c_in, d_in;
   logic [63:0] count_ff, count_in;
   logic [6:0]  round_ff, round_in;      // round index, the pass ends at round 63
   logic [AW:0] pad_ff, pad_in;          // word being padded
   logic        finish_ff, finish_in;    // compression belongs to a finish
   logic        second_ff, second_in;    // the current block is the length-only one
   logic [1:0]  word_ff, word_in;
   logic [7:0]  byte_ff, byte_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0]   wr_data, rd_data;

   md5_ram #(.WIDTH(32), .DEPTH(BufDepth)) u_buf (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // byte position within the block
   logic [5:0] pos;
   assign pos = count_ff[8:3];

   // round unit
   logic [5:0]  rnd;
   logic [31:0] f_val, t_sum, t_rot;
   logic [4:0]  s_amt;
   assign rnd = round_ff[5:0];
   always_comb begin
      case (rnd[5:4])
         2'd0: f_val = d_ff ^ (b_ff & (c_ff ^ d_ff));
         2'd1: f_val = c_ff ^ (d_ff & (b_ff ^ c_ff));
         2'd2: f_val = b_ff ^ c_ff ^ d_ff;
         default: f_val = c_ff ^ (b_ff | ~d_ff);
      endcase
      s_amt = md5_pkg::rot_amount(rnd);
      t_sum = a_ff + f_val + rd_data + md5_pkg::round_k(rnd);
      t_rot = (t_sum << s_amt) | (t_sum >> (6'd32 - {1'b0, s_amt}));
   end

   // padding word for word index pad_idx of the finish block
   logic [31:0]   pad_word;
   logic [AW-1:0] pad_idx;
   assign pad_idx = pad_ff[AW-1:0];
   always_comb begin
      pad_word = 32'h0;
      if (second_ff) begin
         // length-only block: zeros, then the bit count
         if (pad_idx == AW'(14)) begin
            pad_word = count_ff[31:0];
         end else if (pad_idx == AW'(15)) begin
            pad_word = count_ff[63:32];
         end
      end else if ((pos < 6'd56) && (pad_idx == AW'(14))) begin
         pad_word = count_ff[31:0];
      end else if ((pos < 6'd56) && (pad_idx == AW'(15))) begin
         pad_word = count_ff[63:32];
      end else if (pad_idx == pos[5:2]) begin
         // word holding the 0x80 marker: keep earlier bytes
         case (pos[1:0])
            2'd0: pad_word = 32'h0000_0080;
            2'd1: pad_word = {16'h0, 8'h80, rd_data[7:0]};
            2'd2: pad_word = {8'h0, 8'h80, rd_data[15:0]};
            default: pad_word = {8'h80, rd_data[23:0]};
         endcase
      end else if (pad_idx < pos[5:2]) begin
         pad_word = rd_data;
      end
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      round_in  = round_ff;
      pad_in    = pad_ff;
      finish_in = finish_ff;
      second_in = second_ff;
      word_in   = word_ff;
      byte_in   = byte_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      for (int j = 0; j < 4; j++) h_in[j] = h_ff[j];
      wr_en   = 1'b0;
      wr_addr = AW'(pos[5:2]);
      wr_data = 32'h0;
      rd_addr = AW'(pos[5:2]);
      req_ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               byte_in = req_data.data_byte;
               if (req_data.command == md5_pkg::CMD_ABSORB) begin
                  state_in = ST_MERGE;
               end else begin
                  finish_in = 1'b1;
                  second_in = 1'b0;
                  pad_in    = '0;
                  state_in  = ST_PAD;
                  rd_addr   = '0;
               end
            end
         end
         ST_MERGE: begin
            // rd_data holds the current word
            wr_en = 1'b1;
            case (pos[1:0])
               2'd0: wr_data = {rd_data[31:8], byte_ff};
               2'd1: wr_data = {rd_data[31:16], byte_ff, rd_data[7:0]};
               2'd2: wr_data = {rd_data[31:24], byte_ff, rd_data[15:0]};
               default: wr_data = {byte_ff, rd_data[23:0]};
            endcase
            count_in = count_ff + 64'd8;
            if (pos == 6'd63) begin
               finish_in = 1'b0;
               round_in  = '0;
               rd_addr   = '0;
               a_in = h_ff[0]; b_in = h_ff[1]; c_in = h_ff[2]; d_in = h_ff[3];
               state_in  = ST_ROUND;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            // rd_data holds word pad_idx
            wr_en   = 1'b1;
            wr_addr = pad_idx;
            wr_data = pad_word;
            pad_in  = pad_ff + 1'b1;
            rd_addr = AW'(pad_ff + 1'b1);
            if (pad_idx == AW'(BufDepth - 1)) begin
               round_in = '0;
               rd_addr  = '0;
               a_in = h_ff[0]; b_in = h_ff[1]; c_in = h_ff[2]; d_in = h_ff[3];
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            a_in = d_ff;
            d_in = c_ff;
            c_in = b_ff;
            b_in = b_ff + t_rot;
            round_in = round_ff + 1'b1;
            rd_addr  = AW'(md5_pkg::msg_index(6'(round_ff + 1'b1)));
            if (rnd == 6'd63) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            h_in[0] = h_ff[0] + a_ff;
            h_in[1] = h_ff[1] + b_ff;
            h_in[2] = h_ff[2] + c_ff;
            h_in[3] = h_ff[3] + d_ff;
            if (!finish_ff) begin
               state_in = ST_IDLE;
            end else if (!second_ff && pos >= 6'd56) begin
               // second block: zeros then the bit count
               second_in = 1'b1;
               pad_in    = '0;
               rd_addr   = '0;
               state_in  = ST_PAD;
            end else begin
               word_in  = 2'd0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               word_in = word_ff + 1'b1;
               if (word_ff == 2'd3) begin
                  h_in[0] = md5_pkg::INIT_A;
                  h_in[1] = md5_pkg::INIT_B;
                  h_in[2] = md5_pkg::INIT_C;
                  h_in[3] = md5_pkg::INIT_D;
                  count_in  = '0;
                  finish_in = 1'b0;
                  second_in = 1'b0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_data.digest_word = h_ff[word_ff];
   assign rsp_data.word_index  = word_ff;
   assign rsp_data.last_word   = (word_ff == 2'd3);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         finish_ff <= 1'b0;
         second_ff <= 1'b0;
         h_ff[0] <= md5_pkg::INIT_A;
         h_ff[1] <= md5_pkg::INIT_B;
         h_ff[2] <= md5_pkg::INIT_C;
         h_ff[3] <= md5_pkg::INIT_D;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         finish_ff <= finish_in;
         second_ff <= second_in;
         for (int j = 0; j < 4; j++) h_ff[j] <= h_in[j];
      end
      round_ff <= round_in;
      pad_ff   <= pad_in;
      word_ff  <= word_in;
      byte_ff  <= byte_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
   end
endmodule
`default_nettype wire

/* tb/sv/tb_md5_message_digest.sv */
// tb_md5_message_digest: self-checking testbench for the streaming md5 engine
// depends on md5_pkg and the md5_message_digest rtl
// predicts each digest in the testbench and compares every word of the rsp stream
`default_nettype none
module tb_md5_message_digest;

   localparam int unsigned IdleLimit = 20000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   md5_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   md5_pkg::rsp_type rsp_data;

   md5_message_digest DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // digest predictor state
   logic [31:0] hash_state [4];
   logic [63:0] msg_bits;
   logic [31:0] block_words [16];

   md5_pkg::req_type pending_reqs [$];
   md5_pkg::rsp_type digest_words [$];
   int      hold_mark [$];   // request counts at which the sender waits for drain
   int      sent_count = 0;
   bit      failed = 1'b0;
   bit      stim_done = 1'b0;
   int      idle_cycles = 0;
   int      req_gap = 0;
   int      rsp_gap = 0;

   // acceptance flag sampled at the rising edge for the driver
   logic req_taken = 1'b0;

   // round constants, sine table per rfc 1321
   localparam logic [31:0] SINE_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
   localparam int SHIFTS [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                  4, 11, 16, 23, 6, 10, 15, 21};

   function automatic logic [31:0] rotl(logic [31:0] v, int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   task automatic restart_digest();
      hash_state[0] = md5_pkg::INIT_A;
      hash_state[1] = md5_pkg::INIT_B;
      hash_state[2] = md5_pkg::INIT_C;
      hash_state[3] = md5_pkg::INIT_D;
      msg_bits = '0;
      foreach (block_words[w]) block_words[w] = '0;
   endtask

   task automatic fold_block();
      logic [31:0] a, b, c, d, f, t;
      int g, phase;
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
      for (int i = 0; i < 64; i++) begin
         phase = i / 16;
         case (phase)
            0: begin f = d ^ (b & (c ^ d)); g = i; end
            1: begin f = c ^ (d & (b ^ c)); g = (5 * i + 1) % 16; end
            2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
            default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
         endcase
         t = a + f + block_words[g] + SINE_K[i];
         t = b + rotl(t, SHIFTS[phase * 4 + i % 4]);
         a = d; d = c; c = b; b = t;
      end
      hash_state[0] += a; hash_state[1] += b;
      hash_state[2] += c; hash_state[3] += d;
   endtask

   task automatic store_byte(int pos, logic [7:0] val);
      block_words[pos / 4][(pos % 4) * 8 +: 8] = val;
   endtask

   // advance the predictor by one accepted request, queue any digest words
   task automatic predict_request(md5_pkg::req_type r);
      int pos;
      md5_pkg::rsp_type w;
      pos = int'(msg_bits[8:3]);
      if (r.command == md5_pkg::CMD_ABSORB) begin
         store_byte(pos, r.data_byte);
         msg_bits += 64'd8;
         if (pos == 63) fold_block();
      end else begin
         store_byte(pos, 8'h80);
         for (int k = pos + 1; k < 64; k++) store_byte(k, 8'h00);
         // pad does not leave room for the length: extra block
         if (pos >= 56) begin
            fold_block();
            for (int k = 0; k < 14; k++) block_words[k] = '0;
         end
         block_words[14] = msg_bits[31:0];
         block_words[15] = msg_bits[63:32];
         fold_block();
         for (int k = 0; k < 4; k++) begin
            w.digest_word = hash_state[k];
            w.word_index = 2'(k);
            w.last_word = (k == 3);
            digest_words.push_back(w);
         end
         restart_digest();
      end
   endtask

   task automatic add_message(int len);
      md5_pkg::req_type r;
      for (int i = 0; i < len; i++) begin
         r.command = md5_pkg::CMD_ABSORB;
         r.data_byte = 8'($urandom);
         pending_reqs.push_back(r);
      end
      r.command = md5_pkg::CMD_FINISH;
      r.data_byte = 8'($urandom);
      pending_reqs.push_back(r);
   endtask

   task automatic add_fixed_message(int len, logic [7:0] val);
      md5_pkg::req_type r;
      for (int i = 0; i < len; i++) begin
         r.command = md5_pkg::CMD_ABSORB;
         r.data_byte = val;
         pending_reqs.push_back(r);
      end
      r.command = md5_pkg::CMD_FINISH;
      r.data_byte = 8'hff;
      pending_reqs.push_back(r);
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // stimulus: directed messages first, then random-length random messages
   initial begin
      int len, roll;
      restart_digest();
      add_fixed_message(0, 8'h00);      // empty message
      add_fixed_message(1, 8'h00);
      add_fixed_message(1, 8'hff);
      add_fixed_message(3, 8'ha5);
      hold_mark.push_back(pending_reqs.size());
      add_fixed_message(55, 8'h5a);     // length just fits in one block
      add_fixed_message(56, 8'h00);     // padding spills into a second block
      add_fixed_message(63, 8'hff);
      add_fixed_message(64, 8'h3c);     // exactly one full block
      add_fixed_message(65, 8'hc3);
      hold_mark.push_back(pending_reqs.size());
      // random part: mostly short messages, a few crossing block boundaries
      while (pending_reqs.size() < 450) begin
         roll = $urandom_range(0, 99);
         if (roll < 60) len = $urandom_range(0, 8);
         else if (roll < 85) len = $urandom_range(50, 70);
         else len = $urandom_range(9, 140);
         add_message(len);
         if ($urandom_range(0, 9) == 0) hold_mark.push_back(pending_reqs.size());
      end
   end

   // driver: requests change on the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (hold_mark.size() > 0 && hold_mark[0] == sent_count
                         && digest_words.size() != 0) begin
               // sender holds off until every digest has drained
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               if (hold_mark.size() > 0 && hold_mark[0] == sent_count) begin
                  void'(hold_mark.pop_front());
               end
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_gap <= pick_gap();
            end else begin
               req_valid <= 1'b0;
               stim_done <= 1'b1;
            end
         end
         rsp_ready <= (rsp_gap == 0);
         rsp_gap <= (rsp_gap > 0) ? rsp_gap - 1 : pick_gap();
      end
   end

   // monitor: samples both channels at the rising edge
   always @(posedge clock) begin
      md5_pkg::rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            predict_request(req_data);
            sent_count <= sent_count + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (digest_words.size() == 0) begin
               $display("%0t: unexpected digest word, expected none actual %h",
                        $time, rsp_data);
               failed <= 1'b1;
            end else begin
               want = digest_words.pop_front();
               if (rsp_data.digest_word !== want.digest_word)
                  $display("%0t: digest_word expected %h actual %h", $time,
                           want.digest_word, rsp_data.digest_word);
               if (rsp_data.word_index !== want.word_index)
                  $display("%0t: word_index expected %0d actual %0d", $time,
                           want.word_index, rsp_data.word_index);
               if (rsp_data.last_word !== want.last_word)
                  $display("%0t: last_word expected %b actual %b", $time,
                           want.last_word, rsp_data.last_word);
               if (rsp_data !== want) failed <= 1'b1;
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // run control
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      while (!(stim_done && digest_words.size() == 0) && idle_cycles < IdleLimit) begin
         @(posedge clock);
      end
      if (idle_cycles < IdleLimit) begin
         repeat (200) @(posedge clock);
      end
      if (idle_cycles >= IdleLimit) begin
         $display("FAILURE");
      end else if (!failed && digest_words.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
`default_nettype wire
